FILE: design/aas_pkg.sv
// Shared types, register indexes and arithmetic widths for the accelerometer align and smooth block.
package aas_pkg;

  localparam int unsigned COEF_FRAC_BITS_DEF = 14;
  localparam int unsigned ACCEL_WIDTH_DEF    = 24;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned ALPHA_W   = 17;
  localparam int unsigned NUM_AXES  = 3;

  // offset difference, signed gain, product and scaled Q.16 widths
  localparam int unsigned DIFF_W  = RAW_W + 2;
  localparam int unsigned SGAIN_W = GAIN_W + 1;
  localparam int unsigned MUL_W   = DIFF_W + SGAIN_W;
  localparam int unsigned SCL_W   = MUL_W - 8;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd7;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd4096;
  localparam logic [CFG_W-1:0]   ROW0_RST  = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0]   ROW1_RST  = 48'h0000_4000_0000;
  localparam logic [CFG_W-1:0]   ROW2_RST  = 48'h4000_0000_0000;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  typedef struct packed {
    logic signed [RAW_W-1:0] offset_x;
    logic signed [RAW_W-1:0] offset_y;
    logic signed [RAW_W-1:0] offset_z;
    logic [GAIN_W-1:0]       counts_to_g;
    logic [CFG_W-1:0]        row0;
    logic [CFG_W-1:0]        row1;
    logic [CFG_W-1:0]        row2;
    logic [ALPHA_W-1:0]      alpha;
  } cfg_t;

  // item as classified by the front end
  typedef struct packed {
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [RAW_W-1:0]  raw_z;
    logic              changed;
    logic              valid;
    logic [TIME_W-1:0] change_time;
  } qent_t;

  typedef struct packed {
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [RAW_W-1:0]  raw_z;
    logic [OUT_W-1:0]  smooth_x;
    logic [OUT_W-1:0]  smooth_y;
    logic [OUT_W-1:0]  smooth_z;
    logic [OUT_W-1:0]  magnitude;
    logic              valid;
    logic              changed;
    logic [TIME_W-1:0] change_time;
  } res_t;

  typedef struct packed {
    logic idle;
    logic out_valid;
  } back_stat_t;

endpackage

FILE: design/aas_queue.sv
// Short register queue between the front end and the arithmetic back end.
module aas_queue #(
  parameter int unsigned DEPTH = aas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  aas_pkg::qent_t wdata_i,
  input  logic          rd_i,
  output aas_pkg::qent_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import aas_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  qent_t         mem_q [DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
    end
    if (do_rd) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

FILE: design/aas_front.sv
// Front end: assembles the raw axes, detects change and tracks the change time.
module aas_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          full_i,
  input  logic [aas_pkg::BYTE_W-1:0]    x_high_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]    x_low_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]    y_high_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]    y_low_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]    z_high_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]    z_low_byte_i,
  input  logic [aas_pkg::TIME_W-1:0]    now_ms_i,
  output logic                          wr_o,
  output aas_pkg::qent_t                 ent_o
);
  import aas_pkg::*;

  logic [RAW_W-1:0]  prev_x_q, prev_y_q, prev_z_q;
  logic              valid_q, valid_d;
  logic [TIME_W-1:0] chg_q, chg_d;
  logic [RAW_W-1:0]  rx, ry, rz;
  logic              changed;

  assign rx      = {x_high_byte_i, x_low_byte_i};
  assign ry      = {y_high_byte_i, y_low_byte_i};
  assign rz      = {z_high_byte_i, z_low_byte_i};
  assign changed = (rx != prev_x_q) || (ry != prev_y_q) || (rz != prev_z_q);
  assign wr_o    = push_i && !full_i;
  assign valid_d = valid_q || changed;
  assign chg_d   = changed ? now_ms_i : chg_q;

  always_comb begin
    ent_o.raw_x       = rx;
    ent_o.raw_y       = ry;
    ent_o.raw_z       = rz;
    ent_o.changed     = changed;
    ent_o.valid       = valid_d;
    ent_o.change_time = chg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
      valid_q  <= 1'b0;
      chg_q    <= '0;
    end else if (wr_o) begin
      prev_x_q <= rx;
      prev_y_q <= ry;
      prev_z_q <= rz;
      valid_q  <= valid_d;
      chg_q    <= chg_d;
    end
  end

endmodule

FILE: design/aas_back.sv
// Back end: scaling, alignment, smoothing and magnitude over a shared sequencer.
module aas_back #(
  parameter int unsigned COEF_FRAC_BITS = aas_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned ACCEL_WIDTH    = aas_pkg::ACCEL_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aas_pkg::cfg_t       cfg_i,
  input  logic               q_empty_i,
  input  aas_pkg::qent_t      q_data_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output aas_pkg::res_t       res_o,
  output aas_pkg::back_stat_t stat_o
);
  import aas_pkg::*;

  localparam int unsigned AW     = ACCEL_WIDTH;
  localparam int unsigned F      = COEF_FRAC_BITS;
  localparam int unsigned PROD_W = COEF_W + SCL_W;
  localparam int unsigned ROT_W  = PROD_W + 2;
  localparam int unsigned SM_W   = AW + 19;
  localparam int unsigned SQ_W   = 2 * AW;
  localparam int unsigned SW     = 2 * AW + 2;
  localparam int unsigned RW     = AW + 1;

  localparam logic signed [ROT_W-1:0] ROT_HI  = $signed({{(ROT_W-AW+1){1'b0}}, {(AW-1){1'b1}}});
  localparam logic signed [ROT_W-1:0] ROT_LO  = ~ROT_HI;
  localparam logic signed [ROT_W-1:0] ROT_RND = ROT_W'(1) << (F - 1);
  localparam logic signed [SM_W-1:0]  SM_HI   = $signed({{(SM_W-AW+1){1'b0}}, {(AW-1){1'b1}}});
  localparam logic signed [SM_W-1:0]  SM_LO   = ~SM_HI;
  localparam logic signed [SM_W-1:0]  SM_RND  = SM_W'(32768);
  localparam logic signed [MUL_W-1:0] SC_RND  = MUL_W'(128);
  localparam logic [SW-1:0]           BIT_TOP = SW'(1) << (SW - 2);
  localparam logic [SW-1:0]           MAG_MAX = SW'(24'hFFFFFF);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCALE  = 3'd1;
  localparam logic [2:0] ST_ROT    = 3'd2;
  localparam logic [2:0] ST_SMOOTH = 3'd3;
  localparam logic [2:0] ST_SQ     = 3'd4;
  localparam logic [2:0] ST_ROOT   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]                 st_q, st_d;
  logic [1:0]                 cnt_q, cnt_d;
  qent_t                      item_q;
  logic signed [SCL_W-1:0]    sc_q  [NUM_AXES];
  logic signed [SCL_W-1:0]    sc_d  [NUM_AXES];
  logic signed [AW-1:0]       rot_q [NUM_AXES];
  logic signed [AW-1:0]       filt_q[NUM_AXES];
  logic [SW-1:0]              sum_q, rem_q, res_q, bit_q;
  logic                       out_valid_q;
  res_t                       out_q;

  logic [CFG_W-1:0]           row;
  logic signed [PROD_W-1:0]   p0, p1, p2;
  logic signed [ROT_W-1:0]    racc, rsh;
  logic signed [AW-1:0]       rot_new;
  logic [ALPHA_W-1:0]         a_clip;
  logic signed [ALPHA_W:0]    wa, wb;
  logic signed [SM_W-1:0]     sacc, ssh;
  logic signed [AW-1:0]       filt_new;
  logic signed [SQ_W-1:0]     sq;
  logic [SW-1:0]              sum_new, trial;
  logic                       out_free;

  function automatic logic [OUT_W-1:0] to_out(input logic signed [AW-1:0] f);
    logic [AW+OUT_W-1:0] e;
    e = {{OUT_W{f[AW-1]}}, f};
    return e[OUT_W-1:0];
  endfunction

  function automatic logic signed [SCL_W-1:0] scale(input logic signed [DIFF_W-1:0] d,
                                                    input logic [GAIN_W-1:0] g);
    logic signed [MUL_W-1:0] m;
    logic signed [MUL_W-1:0] s;
    m = MUL_W'(d) * MUL_W'($signed({1'b0, g}));
    s = (m + SC_RND) >>> 8;
    return s[SCL_W-1:0];
  endfunction

  // raw differences, X and Z negated
  always_comb begin
    sc_d[0] = scale(DIFF_W'(cfg_i.offset_x) - DIFF_W'($signed(item_q.raw_x)),
                    cfg_i.counts_to_g);
    sc_d[1] = scale(DIFF_W'($signed(item_q.raw_y)) - DIFF_W'(cfg_i.offset_y),
                    cfg_i.counts_to_g);
    sc_d[2] = scale(DIFF_W'(cfg_i.offset_z) - DIFF_W'($signed(item_q.raw_z)),
                    cfg_i.counts_to_g);
  end

  always_comb begin
    case (cnt_q)
      2'd0:    row = cfg_i.row0;
      2'd1:    row = cfg_i.row1;
      default: row = cfg_i.row2;
    endcase
    p0   = PROD_W'($signed(row[15:0]))  * PROD_W'(sc_q[0]);
    p1   = PROD_W'($signed(row[31:16])) * PROD_W'(sc_q[1]);
    p2   = PROD_W'($signed(row[47:32])) * PROD_W'(sc_q[2]);
    racc = ROT_W'(p0) + ROT_W'(p1) + ROT_W'(p2) + ROT_RND;
    rsh  = racc >>> F;
    if (rsh > ROT_HI) begin
      rot_new = ROT_HI[AW-1:0];
    end else if (rsh < ROT_LO) begin
      rot_new = ROT_LO[AW-1:0];
    end else begin
      rot_new = rsh[AW-1:0];
    end
  end

  always_comb begin
    a_clip = (cfg_i.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_i.alpha;
    wb     = $signed({1'b0, a_clip});
    wa     = $signed({1'b0, ALPHA_ONE}) - wb;
    sacc   = SM_W'(filt_q[cnt_q]) * SM_W'(wa) + SM_W'(rot_q[cnt_q]) * SM_W'(wb) + SM_RND;
    ssh    = sacc >>> 16;
    if (ssh > SM_HI) begin
      filt_new = SM_HI[AW-1:0];
    end else if (ssh < SM_LO) begin
      filt_new = SM_LO[AW-1:0];
    end else begin
      filt_new = ssh[AW-1:0];
    end
  end

  assign sq       = SQ_W'(filt_q[cnt_q]) * SQ_W'(filt_q[cnt_q]);
  assign sum_new  = ((cnt_q == 2'd0) ? '0 : sum_q) + SW'($unsigned(sq));
  assign trial    = res_q + bit_q;
  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    q_pop_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          st_d    = ST_SCALE;
        end
      end
      ST_SCALE: begin
        st_d  = ST_ROT;
        cnt_d = 2'd0;
      end
      ST_ROT: begin
        cnt_d = (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          st_d = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        cnt_d = (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          st_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cnt_d = (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          st_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (bit_q[0]) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        filt_q[i] <= '0;
      end
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (st_q == ST_SMOOTH) begin
        filt_q[cnt_q] <= filt_new;
      end
      if (st_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          item_q <= q_data_i;
        end
      end
      ST_SCALE: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          sc_q[i] <= sc_d[i];
        end
      end
      ST_ROT: begin
        rot_q[cnt_q] <= rot_new;
      end
      ST_SQ: begin
        sum_q <= sum_new;
        rem_q <= sum_new;
        res_q <= '0;
        bit_q <= BIT_TOP;
      end
      ST_ROOT: begin
        // one root bit per cycle
        if (rem_q >= trial) begin
          rem_q <= rem_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_DONE: begin
        if (out_free) begin
          out_q.raw_x       <= item_q.raw_x;
          out_q.raw_y       <= item_q.raw_y;
          out_q.raw_z       <= item_q.raw_z;
          out_q.smooth_x    <= to_out(filt_q[0]);
          out_q.smooth_y    <= to_out(filt_q[1]);
          out_q.smooth_z    <= to_out(filt_q[2]);
          out_q.magnitude   <= (res_q > MAG_MAX) ? OUT_W'(24'hFFFFFF) : res_q[OUT_W-1:0];
          out_q.valid       <= item_q.valid;
          out_q.changed     <= item_q.changed;
          out_q.change_time <= item_q.change_time;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o            = out_q;
  assign stat_o.idle      = (st_q == ST_IDLE);
  assign stat_o.out_valid = out_valid_q;

endmodule

FILE: design/accel_align_and_smooth_top.sv
// Each item is scaled, then passes over the three axes for rotation, smoothing and
// squares, then a one-bit-per-cycle square root; the back end takes no new item
// until the last result is loaded.
// A two-entry queue takes push while the back end is busy, until the queue is full.
// Reset (async, active low) clears control, the previous sample, filter state and
// loads the register defaults: zero offsets, identity matrix, alpha of one.
module accel_align_and_smooth_top #(
  parameter int unsigned COEF_FRAC_BITS = aas_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned ACCEL_WIDTH    = aas_pkg::ACCEL_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [aas_pkg::BYTE_W-1:0]       x_high_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]       x_low_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]       y_high_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]       y_low_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]       z_high_byte_i,
  input  logic [aas_pkg::BYTE_W-1:0]       z_low_byte_i,
  input  logic [aas_pkg::TIME_W-1:0]       now_ms_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [aas_pkg::RAW_W-1:0] raw_x_o,
  output logic signed [aas_pkg::RAW_W-1:0] raw_y_o,
  output logic signed [aas_pkg::RAW_W-1:0] raw_z_o,
  output logic signed [aas_pkg::OUT_W-1:0] smooth_x_o,
  output logic signed [aas_pkg::OUT_W-1:0] smooth_y_o,
  output logic signed [aas_pkg::OUT_W-1:0] smooth_z_o,
  output logic [aas_pkg::OUT_W-1:0]        magnitude_o,
  output logic                             data_valid_o,
  output logic                             data_changed_o,
  output logic [aas_pkg::TIME_W-1:0]       change_time_ms_o,
  input  logic                             cfg_we_i,
  input  logic [aas_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [aas_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import aas_pkg::*;

  cfg_t       cfg_q;
  qent_t      ent, q_data;
  logic       q_wr, q_pop, q_empty, q_full;
  res_t       res;
  back_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x    <= '0;
      cfg_q.offset_y    <= '0;
      cfg_q.offset_z    <= '0;
      cfg_q.counts_to_g <= GAIN_RST;
      cfg_q.row0        <= ROW0_RST;
      cfg_q.row1        <= ROW1_RST;
      cfg_q.row2        <= ROW2_RST;
      cfg_q.alpha       <= ALPHA_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFFSET_X: cfg_q.offset_x    <= cfg_wdata_i[RAW_W-1:0];
        REG_OFFSET_Y: cfg_q.offset_y    <= cfg_wdata_i[RAW_W-1:0];
        REG_OFFSET_Z: cfg_q.offset_z    <= cfg_wdata_i[RAW_W-1:0];
        REG_GAIN:     cfg_q.counts_to_g <= cfg_wdata_i[GAIN_W-1:0];
        REG_ROW0:     cfg_q.row0        <= cfg_wdata_i;
        REG_ROW1:     cfg_q.row1        <= cfg_wdata_i;
        REG_ROW2:     cfg_q.row2        <= cfg_wdata_i;
        REG_ALPHA:    cfg_q.alpha       <= cfg_wdata_i[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aas_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (q_full),
    .x_high_byte_i (x_high_byte_i),
    .x_low_byte_i  (x_low_byte_i),
    .y_high_byte_i (y_high_byte_i),
    .y_low_byte_i  (y_low_byte_i),
    .z_high_byte_i (z_high_byte_i),
    .z_low_byte_i  (z_low_byte_i),
    .now_ms_i      (now_ms_i),
    .wr_o          (q_wr),
    .ent_o         (ent)
  );

  aas_queue #(
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (ent),
    .rd_i    (q_pop),
    .rdata_o (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  aas_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACCEL_WIDTH    (ACCEL_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .res_o     (res),
    .stat_o    (stat)
  );

  assign full             = q_full;
  assign empty            = !stat.out_valid;
  assign raw_x_o          = res.raw_x;
  assign raw_y_o          = res.raw_y;
  assign raw_z_o          = res.raw_z;
  assign smooth_x_o       = res.smooth_x;
  assign smooth_y_o       = res.smooth_y;
  assign smooth_z_o       = res.smooth_z;
  assign magnitude_o      = res.magnitude;
  assign data_valid_o     = res.valid;
  assign data_changed_o   = res.changed;
  assign change_time_ms_o = res.change_time;

  // an accepted item lands in the queue
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !q_empty)
    else $error("accepted item not queued");

  // a result appears only as the sequencer returns to idle
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> stat.idle)
    else $error("result loaded outside completion");

  a_changed_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && data_changed_o) |-> data_valid_o)
    else $error("changed item without sticky valid");

  a_time_zero_until_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !data_valid_o) |-> (change_time_ms_o == '0))
    else $error("change time set before any change");

endmodule
